// ----- src/adrc_pkg.sv -----
package adrc_pkg;

  // Field and register widths.
  localparam int unsigned POS_W      = 16;
  localparam int unsigned AXIS_W     = 2;
  localparam int unsigned DZ_W       = 15;
  localparam int unsigned MARKS_W    = 64;
  localparam int unsigned LAST_W     = 24;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 64;

  // Number of axes and marks per curve.
  localparam int unsigned NUM_AXES  = 3;
  localparam int unsigned NUM_MARKS = 9;

  // Axis codes.
  localparam logic [AXIS_W-1:0] AXIS_YAW  = 2'd2;
  localparam logic [AXIS_W-1:0] AXIS_NONE = 2'd3;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_DZ_PITCH    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DZ_ROLL     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DZ_YAW      = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_MARKS_PITCH = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_MARKS_ROLL  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_MARKS_YAW   = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_LAST_MARKS  = 3'd6;

  // Stick centre.
  localparam logic [POS_W-1:0] CENTRE = 16'h8000;

  // Dead zone divider: one quotient bit comes from the entry stage, the
  // remaining ones are resolved a few per pipeline stage.
  localparam int unsigned DIV_STEPS           = 15;
  localparam int unsigned DIV_STEPS_PER_STAGE = 3;
  localparam int unsigned DIV_STAGES          = DIV_STEPS / DIV_STEPS_PER_STAGE;

  // One item as it travels between the two halves of the pipeline.
  typedef struct packed {
    logic [POS_W-1:0]  pos;
    logic [AXIS_W-1:0] axis;
  } item_t;

  // Nine gain marks of one axis, mark zero in entry zero.
  typedef logic [NUM_MARKS-1:0][7:0] curve_t;

endpackage

// ----- src/adrc_deadzone.sv -----
module adrc_deadzone (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  input  adrc_pkg::item_t             in_item_i,
  input  logic [adrc_pkg::DZ_W-1:0]   deadzone_i,
  output logic                        out_valid_o,
  output adrc_pkg::item_t             out_item_o
);

  typedef struct packed {
    logic [adrc_pkg::POS_W-1:0]  raw;
    logic [adrc_pkg::AXIS_W-1:0] axis;
    logic                        neg;
    logic                        bypass;
    logic                        in_zone;
    logic [adrc_pkg::POS_W-1:0]  den;
    logic [adrc_pkg::POS_W-1:0]  rem;
    logic [adrc_pkg::POS_W-1:0]  quo;
  } dz_div_t;

  logic [adrc_pkg::DIV_STAGES:0] vld_q;
  dz_div_t                       div_q [adrc_pkg::DIV_STAGES+1];
  dz_div_t                       entry_d;
  logic                          out_vld_q;
  adrc_pkg::item_t               out_q;
  adrc_pkg::item_t               out_d;

  // Entry stage: offset magnitude, dead zone test and the top quotient bit.
  always_comb begin
    logic [adrc_pkg::POS_W-1:0] mag;
    logic [adrc_pkg::POS_W-1:0] d16;
    logic [adrc_pkg::POS_W-1:0] num;
    logic                       top;
    entry_d.raw     = in_item_i.pos;
    entry_d.axis    = in_item_i.axis;
    entry_d.neg     = ~in_item_i.pos[adrc_pkg::POS_W-1];
    mag             = entry_d.neg ? adrc_pkg::CENTRE - in_item_i.pos
                                  : {1'b0, in_item_i.pos[adrc_pkg::POS_W-2:0]};
    d16             = {1'b0, deadzone_i};
    entry_d.bypass  = (deadzone_i == '0);
    entry_d.in_zone = (mag < d16);
    num             = mag - d16;
    entry_d.den     = adrc_pkg::CENTRE - d16;
    // The scaled offset never exceeds the span, so the top bit is a plain compare.
    top             = (num >= entry_d.den);
    entry_d.rem     = top ? num - entry_d.den : num;
    entry_d.quo     = {{(adrc_pkg::POS_W-1){1'b0}}, top};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q[0] <= 1'b0;
    end else begin
      vld_q[0] <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    div_q[0] <= entry_d;
  end

  // Restoring division stages, a few quotient bits each.
  for (genvar g = 0; g < adrc_pkg::DIV_STAGES; g++) begin : g_div
    dz_div_t nxt;

    always_comb begin
      logic [adrc_pkg::POS_W:0] r2;
      logic                     ge;
      nxt = div_q[g];
      for (int s = 0; s < adrc_pkg::DIV_STEPS_PER_STAGE; s++) begin
        r2      = {nxt.rem, 1'b0};
        ge      = (r2 >= {1'b0, nxt.den});
        nxt.rem = ge ? adrc_pkg::POS_W'(r2 - {1'b0, nxt.den}) : r2[adrc_pkg::POS_W-1:0];
        nxt.quo = {nxt.quo[adrc_pkg::POS_W-2:0], ge};
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[g+1] <= 1'b0;
      end else begin
        vld_q[g+1] <= vld_q[g];
      end
    end

    always_ff @(posedge clk_i) begin
      div_q[g+1] <= nxt;
    end
  end

  // Rebuild the position around the centre, or pass the raw position when the dead zone is zero.
  always_comb begin
    dz_div_t last;
    last       = div_q[adrc_pkg::DIV_STAGES];
    out_d.axis = last.axis;
    if (last.bypass) begin
      out_d.pos = last.raw;
    end else if (last.in_zone) begin
      out_d.pos = adrc_pkg::CENTRE;
    end else if (last.neg) begin
      out_d.pos = adrc_pkg::CENTRE - last.quo;
    end else begin
      out_d.pos = adrc_pkg::CENTRE + last.quo;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else begin
      out_vld_q <= vld_q[adrc_pkg::DIV_STAGES];
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  assign out_valid_o = out_vld_q;
  assign out_item_o  = out_q;

endmodule

// ----- src/adrc_curve.sv -----
module adrc_curve (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  input  adrc_pkg::item_t             in_item_i,
  input  adrc_pkg::curve_t            curves_i [adrc_pkg::NUM_AXES],
  output logic                        out_valid_o,
  output logic [adrc_pkg::POS_W-1:0]  deadzoned_o,
  output logic [adrc_pkg::POS_W-1:0]  shaped_o
);

  localparam logic [3:0] LastBin  = 4'd9;
  localparam logic [3:0] LastMark = 4'd8;

  logic [3:0] vld_q;

  // Stage 1: bin, fraction and the two bounding marks.
  logic                       neg_d, neg1_q;
  logic [adrc_pkg::POS_W-1:0] mag_d, mag1_q, dz1_q;
  logic [14:0]                frac_d, frac1_q;
  logic [7:0]                 lo_d, lo1_q, hi_d, hi1_q;

  always_comb begin
    logic [19:0] t;
    logic [3:0]  bin;
    logic [3:0]  lo_idx;
    logic [3:0]  hi_idx;
    neg_d  = ~in_item_i.pos[adrc_pkg::POS_W-1];
    mag_d  = neg_d ? adrc_pkg::CENTRE - in_item_i.pos
                   : {1'b0, in_item_i.pos[adrc_pkg::POS_W-2:0]};
    t      = 20'({mag_d, 3'b000}) + 20'({mag_d, 1'b0});
    bin    = (t[18:15] > LastBin) ? LastBin : t[18:15];
    frac_d = t[14:0];
    lo_idx = (bin == '0) ? 4'd0 : bin - 4'd1;
    hi_idx = (bin == LastBin) ? LastMark : bin;
    lo_d   = curves_i[in_item_i.axis][lo_idx];
    hi_d   = curves_i[in_item_i.axis][hi_idx];
  end

  always_ff @(posedge clk_i) begin
    neg1_q  <= neg_d;
    mag1_q  <= mag_d;
    dz1_q   <= in_item_i.pos;
    frac1_q <= frac_d;
    lo1_q   <= lo_d;
    hi1_q   <= hi_d;
  end

  // Stage 2: weight each mark by its share of the bin.
  logic                       neg2_q;
  logic [adrc_pkg::POS_W-1:0] mag2_q, dz2_q;
  logic [23:0]                plo_d, plo2_q, phi_d, phi2_q;

  always_comb begin
    logic [adrc_pkg::POS_W-1:0] inv;
    inv   = adrc_pkg::CENTRE - {1'b0, frac1_q};
    plo_d = 24'(lo1_q) * 24'(inv);
    phi_d = 24'(hi1_q) * 24'(frac1_q);
  end

  always_ff @(posedge clk_i) begin
    neg2_q <= neg1_q;
    mag2_q <= mag1_q;
    dz2_q  <= dz1_q;
    plo2_q <= plo_d;
    phi2_q <= phi_d;
  end

  // Stage 3: gain and the scaled magnitude.
  logic                       neg3_q;
  logic [adrc_pkg::POS_W-1:0] dz3_q;
  logic [30:0]                prod_d, prod3_q;

  always_comb begin
    logic [23:0] sum;
    sum    = plo2_q + phi2_q;
    prod_d = 31'(mag2_q) * 31'(sum[22:8]);
  end

  always_ff @(posedge clk_i) begin
    neg3_q  <= neg2_q;
    dz3_q   <= dz2_q;
    prod3_q <= prod_d;
  end

  // Stage 4: back around the centre.
  logic [adrc_pkg::POS_W-1:0] dz4_q, sh_d, sh4_q;

  always_comb begin
    logic [adrc_pkg::POS_W-1:0] q;
    q    = prod3_q[30:15];
    sh_d = neg3_q ? adrc_pkg::CENTRE - q : adrc_pkg::CENTRE + q;
  end

  always_ff @(posedge clk_i) begin
    dz4_q <= dz3_q;
    sh4_q <= sh_d;
  end

  // Valid bits follow the data through the four stages.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[2:0], in_valid_i};
    end
  end

  assign out_valid_o = vld_q[3];
  assign deadzoned_o = dz4_q;
  assign shaped_o    = sh4_q;

endmodule

// ----- src/axis_deadzone_response_curve.sv -----
// Channel   Handshake            Payload
// -------   ------------------   ----------------------------------------
// input     start / busy         raw_position_i, axis_select_i
// result    result_valid_o       deadzoned_position_o, shaped_position_o
// config    cfg_we_i             cfg_idx_i, cfg_wdata_i
//
// One item is accepted in every cycle; busy stays low.
// Each result passes through the pipelined dead
// zone divider (seven stages) followed by the four stage gain curve.
// Reset clears all valid bits and loads the default dead zones and marks.
// The receiver cannot stall, so the pipeline advances in every cycle.
module axis_deadzone_response_curve (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                start,
  output logic                                busy,
  input  logic [adrc_pkg::POS_W-1:0]          raw_position_i,
  input  logic [adrc_pkg::AXIS_W-1:0]         axis_select_i,
  output logic                                result_valid_o,
  output logic [adrc_pkg::POS_W-1:0]          deadzoned_position_o,
  output logic [adrc_pkg::POS_W-1:0]          shaped_position_o,
  input  logic                                cfg_we_i,
  input  logic [adrc_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [adrc_pkg::CFG_DATA_W-1:0]     cfg_wdata_i
);

  logic [adrc_pkg::DZ_W-1:0]    dz_q    [adrc_pkg::NUM_AXES];
  logic [adrc_pkg::MARKS_W-1:0] marks_q [adrc_pkg::NUM_AXES];
  logic [adrc_pkg::LAST_W-1:0]  last_q;
  adrc_pkg::curve_t             curves  [adrc_pkg::NUM_AXES];
  adrc_pkg::item_t              in_item;
  logic                         mid_valid;
  adrc_pkg::item_t              mid_item;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int a = 0; a < adrc_pkg::NUM_AXES; a++) begin
        dz_q[a]    <= '0;
        marks_q[a] <= '1;
      end
      last_q <= '1;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        adrc_pkg::REG_DZ_PITCH:    dz_q[0]    <= cfg_wdata_i[adrc_pkg::DZ_W-1:0];
        adrc_pkg::REG_DZ_ROLL:     dz_q[1]    <= cfg_wdata_i[adrc_pkg::DZ_W-1:0];
        adrc_pkg::REG_DZ_YAW:      dz_q[2]    <= cfg_wdata_i[adrc_pkg::DZ_W-1:0];
        adrc_pkg::REG_MARKS_PITCH: marks_q[0] <= cfg_wdata_i;
        adrc_pkg::REG_MARKS_ROLL:  marks_q[1] <= cfg_wdata_i;
        adrc_pkg::REG_MARKS_YAW:   marks_q[2] <= cfg_wdata_i;
        adrc_pkg::REG_LAST_MARKS:  last_q     <= cfg_wdata_i[adrc_pkg::LAST_W-1:0];
        default: ;
      endcase
    end
  end

  // Assemble the nine marks of each axis.
  for (genvar a = 0; a < adrc_pkg::NUM_AXES; a++) begin : g_curve
    assign curves[a] = {last_q[8*a +: 8], marks_q[a]};
  end

  // The unused axis code is served as yaw.
  assign in_item.pos  = raw_position_i;
  assign in_item.axis = (axis_select_i == adrc_pkg::AXIS_NONE) ? adrc_pkg::AXIS_YAW
                                                                : axis_select_i;
  assign busy         = 1'b0;

  adrc_deadzone u_deadzone (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (start),
    .in_item_i   (in_item),
    .deadzone_i  (dz_q[in_item.axis]),
    .out_valid_o (mid_valid),
    .out_item_o  (mid_item)
  );

  adrc_curve u_curve (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (mid_valid),
    .in_item_i   (mid_item),
    .curves_i    (curves),
    .out_valid_o (result_valid_o),
    .deadzoned_o (deadzoned_position_o),
    .shaped_o    (shaped_position_o)
  );

endmodule

// ----- tb/axis_deadzone_response_curve_tb.sv -----
`timescale 1ns / 1ps

module axis_deadzone_response_curve_tb;
  import adrc_pkg::*;

  localparam int unsigned NUM_BINS     = 10;
  localparam int unsigned LAST_BIN     = NUM_BINS - 1;
  localparam int unsigned MARK_SCALE   = 256;
  localparam int unsigned DZ_MAX       = (1 << DZ_W) - 1;
  localparam int unsigned NUM_PHASES   = 10;
  localparam int unsigned PHASE_ITEMS  = 153;
  localparam int unsigned DRAIN_CYCLES = 24;
  localparam int unsigned STALL_LIMIT  = 1000;

  // Index with no register behind it; writes there must change nothing.
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd7;

  // One planned driver action: a sample item or a register write.
  typedef struct {
    bit                    is_write;
    logic [CFG_IDX_W-1:0]  idx;
    logic [CFG_DATA_W-1:0] data;
    logic [POS_W-1:0]      raw;
    logic [AXIS_W-1:0]     sel;
    int unsigned           gap;
  } plan_entry_t;

  // Expected result of one sample, with the sample kept for messages.
  typedef struct {
    logic [POS_W-1:0]  raw;
    logic [AXIS_W-1:0] sel;
    logic [POS_W-1:0]  deadzoned;
    logic [POS_W-1:0]  shaped;
  } response_t;

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  start = 1'b0;
  logic                  busy;
  logic [POS_W-1:0]      raw_position = '0;
  logic [AXIS_W-1:0]     axis_select = '0;
  logic                  result_valid;
  logic [POS_W-1:0]      deadzoned_position;
  logic [POS_W-1:0]      shaped_position;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  plan_entry_t drive_plan[$];
  response_t   pending_responses[$];
  int unsigned plan_dz[NUM_AXES];

  // Shadow copy of the block's registers, updated as writes are accepted.
  logic [DZ_W-1:0] model_dz[NUM_AXES];
  curve_t          model_curve[NUM_AXES];

  int outstanding = 0;
  int idle_cycles = 0;
  int mismatches = 0;

  axis_deadzone_response_curve dut (
    .clk_i                (clk_i),
    .rst_ni               (rst_ni),
    .start                (start),
    .busy                 (busy),
    .raw_position_i       (raw_position),
    .axis_select_i        (axis_select),
    .result_valid_o       (result_valid),
    .deadzoned_position_o (deadzoned_position),
    .shaped_position_o    (shaped_position),
    .cfg_we_i             (cfg_we),
    .cfg_idx_i            (cfg_idx),
    .cfg_wdata_i          (cfg_wdata)
  );

  always #10 clk_i = ~clk_i;

  // Dead zone removal and curve gain for one sample under the shadow registers.
  function automatic response_t shape_sample(input logic [POS_W-1:0] raw,
                                             input logic [AXIS_W-1:0] sel);
    response_t   r;
    int unsigned a, ctr, d, pos, mag, q, t, bin, rem, lo, hi, mult;
    bit          neg;
    ctr = CENTRE;
    a = (sel == AXIS_NONE) ? AXIS_YAW : sel;
    d = model_dz[a];
    pos = raw;
    if (d != 0) begin
      neg = pos < ctr;
      mag = neg ? ctr - pos : pos - ctr;
      if (mag < d) begin
        pos = ctr;
      end else begin
        q = 32'((64'(ctr) * 64'(mag - d)) / 64'(ctr - d));
        pos = neg ? ctr - q : ctr + q;
      end
    end
    r.raw = raw;
    r.sel = sel;
    r.deadzoned = POS_W'(pos);

    // The gain is interpolated inside one of ten bins of the offset.
    pos = POS_W'(pos);
    neg = pos < ctr;
    mag = neg ? ctr - pos : pos - ctr;
    t = NUM_BINS * mag;
    bin = t / ctr;
    rem = t % ctr;
    if (bin > LAST_BIN) bin = LAST_BIN;
    lo = (bin > 0) ? model_curve[a][bin - 1] : model_curve[a][0];
    hi = (bin < LAST_BIN) ? model_curve[a][bin] : model_curve[a][NUM_MARKS - 1];
    mult = (lo * (ctr - rem) + hi * rem) / MARK_SCALE;
    q = 32'((64'(mag) * 64'(mult)) / 64'(ctr));
    r.shaped = POS_W'(neg ? ctr - q : ctr + q);
    return r;
  endfunction

  task automatic push_sample(input int unsigned raw, input int unsigned sel,
                             input int unsigned gap);
    plan_entry_t e;
    e = '{is_write: 1'b0, idx: '0, data: '0, raw: POS_W'(raw), sel: AXIS_W'(sel),
          gap: gap};
    drive_plan.push_back(e);
  endtask

  task automatic push_write(input logic [CFG_IDX_W-1:0] idx,
                            input logic [CFG_DATA_W-1:0] data);
    plan_entry_t e;
    e = '{is_write: 1'b1, idx: idx, data: data, raw: '0, sel: '0, gap: 0};
    drive_plan.push_back(e);
  endtask

  // Sets dead zone and marks zero to seven of one axis. Unused upper bits of
  // the dead zone write carry noise, which the block must ignore.
  task automatic program_axis(input int unsigned a, input int unsigned dz,
                              input logic [MARKS_W-1:0] marks);
    logic [CFG_DATA_W-1:0] data;
    data = {$urandom, $urandom};
    data[DZ_W-1:0] = DZ_W'(dz);
    plan_dz[a] = dz;
    push_write(CFG_IDX_W'(REG_DZ_PITCH + a), data);
    push_write(CFG_IDX_W'(REG_MARKS_PITCH + a), marks);
  endtask

  task automatic program_last_marks(input logic [LAST_W-1:0] marks);
    logic [CFG_DATA_W-1:0] data;
    data = {$urandom, $urandom};
    data[LAST_W-1:0] = marks;
    push_write(REG_LAST_MARKS, data);
  endtask

  function automatic int unsigned pick_deadzone();
    case ($urandom_range(0, 5))
      0: return 0;
      1: return DZ_MAX;
      2: return $urandom_range(1, 64);
      3: return $urandom_range(30000, DZ_MAX);
      default: return $urandom_range(0, DZ_MAX);
    endcase
  endfunction

  function automatic logic [MARKS_W-1:0] pick_marks();
    logic [MARKS_W-1:0] m;
    case ($urandom_range(0, 4))
      0: m = '0;
      1: m = '1;
      2: begin
        // Rising curve, the usual shape in practice.
        for (int k = 0; k < NUM_MARKS - 1; k++) begin
          m[8*k +: 8] = 8'(32 * k + $urandom_range(0, 31));
        end
      end
      default: m = {$urandom, $urandom};
    endcase
    return m;
  endfunction

  // Samples lean toward the centre, the dead zone edges and the bin edges.
  function automatic int unsigned pick_raw(input int unsigned d);
    int v, off;
    int corner[8] = '{0, 1, 2, 32767, 32768, 32769, 65534, 65535};
    off = 0;
    v = -1;
    case ($urandom_range(0, 9))
      0, 1, 2, 3: v = $urandom_range(0, 65535);
      4: off = $urandom_range(0, d + 64);
      5: v = corner[$urandom_range(0, 7)];
      6, 7: off = int'(d) + $urandom_range(0, 2) - 1;
      default: off = ($urandom_range(1, LAST_BIN) * 32768 + 9) / 10
                     + $urandom_range(0, 4) - 2;
    endcase
    if (v < 0) v = $urandom_range(0, 1) ? 32768 + off : 32768 - off;
    if (v < 0) v = 0;
    if (v > 65535) v = 65535;
    return v;
  endfunction

  function automatic int unsigned pick_gap(input bit bursty);
    int unsigned r;
    r = $urandom_range(0, 99);
    if (!bursty || r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Driver: issues planned items and register writes. Writes wait until every
  // result of earlier items has come back.
  always @(posedge clk_i or negedge rst_ni) begin : driver
    plan_entry_t e;
    int unsigned gap_left;
    logic start_n, we_n;
    if (!rst_ni) begin
      start <= 1'b0;
      cfg_we <= 1'b0;
      gap_left = 0;
    end else if (!(start && busy)) begin
      start_n = 1'b0;
      we_n = 1'b0;
      if (gap_left > 0) begin
        gap_left--;
      end else if (drive_plan.size() != 0) begin
        if (!drive_plan[0].is_write) begin
          e = drive_plan.pop_front();
          start_n = 1'b1;
          raw_position <= e.raw;
          axis_select <= e.sel;
          gap_left = e.gap;
        end else if (!start && outstanding == 0) begin
          e = drive_plan.pop_front();
          we_n = 1'b1;
          cfg_idx <= e.idx;
          cfg_wdata <= e.data;
        end
      end
      start <= start_n;
      cfg_we <= we_n;
    end
  end

  // Monitor: checks each result against the oldest expectation, predicts
  // accepted items and tracks register writes.
  always @(posedge clk_i or negedge rst_ni) begin : monitor
    response_t exp_resp;
    bit active;
    if (!rst_ni) begin
      for (int a = 0; a < NUM_AXES; a++) begin
        model_dz[a] = '0;
        model_curve[a] = '1;
      end
      pending_responses.delete();
      outstanding <= 0;
      idle_cycles <= 0;
    end else begin
      active = result_valid || (start && !busy) || cfg_we;
      if (result_valid) begin
        if (pending_responses.size() == 0) begin
          mismatches++;
          $display("%0t: unexpected result: deadzoned %0d shaped %0d", $time,
                   deadzoned_position, shaped_position);
        end else begin
          exp_resp = pending_responses.pop_front();
          if (deadzoned_position !== exp_resp.deadzoned) begin
            mismatches++;
            $display("%0t: raw %0d axis %0d deadzoned: expected %0d, actual %0d",
                     $time, exp_resp.raw, exp_resp.sel, exp_resp.deadzoned,
                     deadzoned_position);
          end
          if (shaped_position !== exp_resp.shaped) begin
            mismatches++;
            $display("%0t: raw %0d axis %0d shaped: expected %0d, actual %0d",
                     $time, exp_resp.raw, exp_resp.sel, exp_resp.shaped,
                     shaped_position);
          end
        end
      end
      if (start && !busy) pending_responses.push_back(shape_sample(raw_position, axis_select));
      if (cfg_we) begin
        case (cfg_idx)
          REG_DZ_PITCH, REG_DZ_ROLL, REG_DZ_YAW: begin
            model_dz[cfg_idx] = cfg_wdata[DZ_W-1:0];
          end
          REG_MARKS_PITCH, REG_MARKS_ROLL, REG_MARKS_YAW: begin
            model_curve[cfg_idx - REG_MARKS_PITCH][NUM_MARKS-2:0] = cfg_wdata;
          end
          REG_LAST_MARKS: begin
            for (int a = 0; a < NUM_AXES; a++) begin
              model_curve[a][NUM_MARKS-1] = cfg_wdata[8*a +: 8];
            end
          end
          default: ;
        endcase
      end
      outstanding <= pending_responses.size();
      idle_cycles <= active ? 0 : idle_cycles + 1;
    end
  end

  // Ends the run if nothing moves for too long.
  initial begin : watchdog
    do @(negedge clk_i); while (idle_cycles < STALL_LIMIT);
    $display("== FAIL ==");
    $finish;
  end

  initial begin : run_control
    int unsigned sel, a;
    bit bursty;

    // Reset values: no dead zone, every mark at full scale.
    push_sample(0, 0, 0);
    push_sample(65535, 1, 0);
    push_sample(32768, AXIS_YAW, 1);
    push_sample(1, AXIS_NONE, 0);
    push_sample(32767, 0, 2);
    push_sample(32769, 1, 0);

    // Mid, widest and narrowest dead zones with distinct curves per axis.
    program_axis(0, 1000, 64'hE0C0_A080_6040_2000);
    program_axis(1, DZ_MAX, 64'h0);
    program_axis(2, 1, 64'h0123_4567_89AB_CDEF);
    program_last_marks(24'hFF_0080);
    push_write(REG_UNUSED, '1);

    // Inside, on and past the dead zone edge, and the outermost samples.
    push_sample(32768 + 999, 0, 0);
    push_sample(32768 - 1000, 0, 0);
    push_sample(32768 + 1001, 0, 1);
    push_sample(0, 0, 0);
    push_sample(65535, 0, 0);
    push_sample(65535, 1, 0);
    push_sample(1, 1, 3);
    push_sample(0, 1, 0);
    push_sample(32768, AXIS_YAW, 0);
    push_sample(32769, AXIS_YAW, 0);
    push_sample(40000, AXIS_NONE, 0);
    push_sample(65535, AXIS_YAW, 0);
    push_sample(1, AXIS_NONE, 0);
    push_sample(0, AXIS_YAW, 0);

    // Random phases, each under its own register setting.
    for (int p = 0; p < NUM_PHASES; p++) begin
      for (int k = 0; k < NUM_AXES; k++) begin
        if (p == 1) program_axis(k, DZ_MAX, '0);
        else if (p == 2) program_axis(k, 0, '1);
        else program_axis(k, pick_deadzone(), pick_marks());
      end
      if (p == 1) program_last_marks('0);
      else if (p == 2) program_last_marks('1);
      else program_last_marks(LAST_W'($urandom));
      bursty = (p % 3) != 0;
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        sel = $urandom_range(0, 3);
        a = (sel == AXIS_NONE) ? AXIS_YAW : sel;
        push_sample(pick_raw(plan_dz[a]), sel, pick_gap(bursty));
      end
    end

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    do @(negedge clk_i); while (drive_plan.size() != 0 || start || outstanding != 0);
    repeat (DRAIN_CYCLES) @(negedge clk_i);
    if (mismatches == 0 && pending_responses.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
src/adrc_pkg.sv
src/adrc_deadzone.sv
src/adrc_curve.sv
src/axis_deadzone_response_curve.sv
tb/axis_deadzone_response_curve_tb.sv
